// ===== hdl/wae_pkg.sv =====
`default_nettype none

package wae_pkg;

  localparam int unsigned MOD_W = 11;

  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [2:0] LAST_WEEKDAY = 3'd6;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_QUERY = 1'b1;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_DUMMY = 2'd2;

  localparam logic       CFG_ENABLE = 1'b0;
  localparam logic       CFG_ACTIVE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [6:0] entry_index;
    logic [2:0] entry_weekday;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_index;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
  } out_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/weekly_alarm_entry_search.sv =====
// A write item, or a query while disabled or with no active entries, goes straight
// to S_FIN; any other query scans the active entries (count capped at TABLE_DEPTH)
// from index 0 via the registered table read, stops at the first hit, else dummy.
// One item at a time: in_ready is high only in S_IDLE, so the next input is taken
// only once the result has moved to the output register (S_FIN waits on out_ready).
// Reset clears control state and config registers; the table is undefined until written.
`default_nettype none

module weekly_alarm_entry_search #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire wae_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output wae_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_wdata
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             en_r;
  logic [7:0]       active_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [2:0]       now_wd_r, now_wd_nxt;
  logic [4:0]       now_hr_r, now_hr_nxt;
  logic [5:0]       now_mn_r, now_mn_nxt;
  wae_pkg::out_t    res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  wae_pkg::out_t    out_data_r, out_data_nxt;

  logic             tbl_we;
  logic [IDX_W-1:0] rd_addr;
  wae_pkg::entry_t  wr_entry;
  wae_pkg::entry_t  rd_entry;
  logic             hit;
  logic             slot_ok;
  logic [CNT_W-1:0] cnt_sat;

  assign wr_entry = '{weekday: in_data.entry_weekday,
                      hour:    in_data.entry_hour,
                      minute:  in_data.entry_minute};
  assign slot_ok  = 32'(in_data.entry_index) < 32'(TABLE_DEPTH);
  assign cnt_sat  = (32'(active_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(active_r);
  assign rd_addr  = issue_r[IDX_W-1:0];

  wae_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .wr_addr (IDX_W'(in_data.entry_index)),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  wae_match u_match (
    .entry       (rd_entry),
    .now_weekday (now_wd_r),
    .now_hour    (now_hr_r),
    .now_minute  (now_mn_r),
    .hit         (hit)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    now_wd_nxt    = now_wd_r;
    now_hr_nxt    = now_hr_r;
    now_mn_nxt    = now_mn_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tbl_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
          if (in_data.op == wae_pkg::OP_WRITE) begin
            tbl_we = slot_ok;
          end else begin
            now_wd_nxt = in_data.now_weekday;
            now_hr_nxt = in_data.now_hour;
            now_mn_nxt = in_data.now_minute;
            count_nxt  = cnt_sat;
            if (en_r && (cnt_sat != '0)) begin
              issue_nxt = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (pend_r && hit) begin
          res_nxt   = '{status:       wae_pkg::ST_FOUND,
                        found_index:  7'(pend_idx_r),
                        alarm_hour:   rd_entry.hour,
                        alarm_minute: rd_entry.minute};
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else if (issue_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r;
          issue_nxt    = issue_r + CNT_W'(1);
        end else begin
          res_nxt   = '{status:       wae_pkg::ST_DUMMY,
                        found_index:  7'd0,
                        alarm_hour:   now_hr_r,
                        alarm_minute: now_mn_r};
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b0;
      active_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == wae_pkg::CFG_ENABLE)) begin
        en_r <= cfg_wdata[0];
      end
      if (cfg_we && (cfg_index == wae_pkg::CFG_ACTIVE)) begin
        active_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    issue_r    <= issue_nxt;
    pend_idx_r <= pend_idx_nxt;
    now_wd_r   <= now_wd_nxt;
    now_hr_r   <= now_hr_nxt;
    now_mn_r   <= now_mn_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (issue_r <= count_r))
    else $error("scan index past active count");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_r) |-> (pend_idx_r < count_r))
    else $error("pending read outside active entries");

  a_found_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_r.status == wae_pkg::ST_FOUND) |-> en_r)
    else $error("entry found while search disabled");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not moved to output register");
`endif

endmodule

`default_nettype wire

// ===== hdl/wae_table.sv =====
`default_nettype none

module wae_table #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire wae_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output wae_pkg::entry_t      rd_data
);

  wae_pkg::entry_t mem [DEPTH];
  wae_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/wae_match.sv =====
`default_nettype none

module wae_match (
  input  wire wae_pkg::entry_t entry,
  input  wire logic [2:0]      now_weekday,
  input  wire logic [4:0]      now_hour,
  input  wire logic [5:0]      now_minute,
  output logic                 hit
);

  logic [wae_pkg::MOD_W-1:0] entry_mod;
  logic [wae_pkg::MOD_W-1:0] now_mod;
  logic [3:0]                next_wd;
  logic                      same_later;
  logic                      next_earlier;

  always_comb begin
    entry_mod = wae_pkg::MOD_W'(entry.hour) * wae_pkg::MOD_W'(wae_pkg::MIN_PER_HOUR)
              + wae_pkg::MOD_W'(entry.minute);
    now_mod   = wae_pkg::MOD_W'(now_hour) * wae_pkg::MOD_W'(wae_pkg::MIN_PER_HOUR)
              + wae_pkg::MOD_W'(now_minute);
    next_wd   = (now_weekday == wae_pkg::LAST_WEEKDAY) ? 4'd0 : {1'b0, now_weekday} + 4'd1;
    same_later   = (entry.weekday == now_weekday) && (entry_mod > now_mod);
    next_earlier = ({1'b0, entry.weekday} == next_wd) && (entry_mod < now_mod);
    hit = same_later || next_earlier;
  end

endmodule

`default_nettype wire

// ===== bench/tb_weekly_alarm_entry_search.sv =====
`timescale 1ns / 100ps

module tb_weekly_alarm_entry_search;

  localparam int TABLE_DEPTH = 128;

  typedef struct {
    wae_pkg::in_t data;
    bit           hold;
  } pend_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  wae_pkg::in_t    in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  wae_pkg::out_t   out_data;
  logic            cfg_we = 1'b0;
  logic            cfg_index = wae_pkg::CFG_ENABLE;
  logic [7:0]      cfg_wdata = '0;

  wae_pkg::entry_t sched_tbl [TABLE_DEPTH];
  logic            sched_en = 1'b0;
  logic [7:0]      active_cnt = '0;
  bit              written [TABLE_DEPTH];
  int              written_upto = 0;

  pend_t           pending [$];
  wae_pkg::out_t   alarm_q [$];
  int              n_pushed = 0;
  int              n_accepted = 0;
  int              results_seen = 0;
  int              mismatches = 0;
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;

  weekly_alarm_entry_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_weekly_alarm_entry_search NOT OK");
    $finish;
  end

  function automatic wae_pkg::out_t next_alarm(input wae_pkg::in_t item);
    wae_pkg::out_t   res;
    int              count;
    int              now_mod;
    int              nxt_wd;
    int              mod;
    wae_pkg::entry_t e;
    res = '0;
    if (item.op == wae_pkg::OP_WRITE) begin
      sched_tbl[item.entry_index] = '{item.entry_weekday, item.entry_hour, item.entry_minute};
      return res;
    end
    count = (active_cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_cnt);
    if (!sched_en || count == 0) return res;
    now_mod = int'(item.now_hour) * int'(wae_pkg::MIN_PER_HOUR) + int'(item.now_minute);
    nxt_wd = (item.now_weekday == wae_pkg::LAST_WEEKDAY) ? 0 : int'(item.now_weekday) + 1;
    for (int i = 0; i < count; i++) begin
      e = sched_tbl[i];
      mod = int'(e.hour) * int'(wae_pkg::MIN_PER_HOUR) + int'(e.minute);
      if ((e.weekday == item.now_weekday && mod > now_mod) ||
          (int'(e.weekday) == nxt_wd && mod < now_mod)) begin
        res.status = wae_pkg::ST_FOUND;
        res.found_index = 7'(i);
        res.alarm_hour = e.hour;
        res.alarm_minute = e.minute;
        return res;
      end
    end
    res.status = wae_pkg::ST_DUMMY;
    res.alarm_hour = item.now_hour;
    res.alarm_minute = item.now_minute;
    return res;
  endfunction

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        alarm_q.push_back(next_alarm(in_data));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
            !(pending[0].hold && n_accepted != results_seen)) begin
          in_valid <= 1'b1;
          in_data <= pending[0].data;
          pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    wae_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (alarm_q.size() == 0) begin
          report("result transfer with no expected alarm");
        end else begin
          want = alarm_q.pop_front();
          if (out_data.status !== want.status)
            report($sformatf("status got %0d want %0d", out_data.status, want.status));
          if (out_data.found_index !== want.found_index)
            report($sformatf("found_index got %0d want %0d",
                             out_data.found_index, want.found_index));
          if (out_data.alarm_hour !== want.alarm_hour)
            report($sformatf("alarm_hour got %0d want %0d",
                             out_data.alarm_hour, want.alarm_hour));
          if (out_data.alarm_minute !== want.alarm_minute)
            report($sformatf("alarm_minute got %0d want %0d",
                             out_data.alarm_minute, want.alarm_minute));
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == wae_pkg::CFG_ENABLE) sched_en = val[0];
    else active_cnt = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (results_seen < n_pushed) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_item(input wae_pkg::in_t item, input bit hold);
    pend_t p;
    p.data = item;
    p.hold = hold;
    pending.push_back(p);
    n_pushed++;
  endtask

  function automatic wae_pkg::in_t rand_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(wae_pkg::in_t)-1:0];
  endfunction

  task automatic push_write(input int idx, input int wd, input int hr, input int mn,
                            input bit hold);
    wae_pkg::in_t item;
    item = rand_item();
    item.op = wae_pkg::OP_WRITE;
    item.entry_index = 7'(idx);
    item.entry_weekday = 3'(wd);
    item.entry_hour = 5'(hr);
    item.entry_minute = 6'(mn);
    written[idx] = 1'b1;
    while (written_upto < TABLE_DEPTH && written[written_upto]) written_upto++;
    push_item(item, hold);
  endtask

  task automatic push_query(input int wd, input int hr, input int mn, input bit hold);
    wae_pkg::in_t item;
    item = rand_item();
    item.op = wae_pkg::OP_QUERY;
    item.now_weekday = 3'(wd);
    item.now_hour = 5'(hr);
    item.now_minute = 6'(mn);
    push_item(item, hold);
  endtask

  function automatic int rand_hour();
    return ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23);
  endfunction

  function automatic int rand_minute();
    return ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
  endfunction

  // weekday that neither matches the hot day nor the day after it
  function automatic int cold_weekday(input int hot, input int nxt);
    int wd;
    wd = $urandom_range(7);
    while (wd == hot || wd == nxt) wd = $urandom_range(7);
    return wd;
  endfunction

  initial begin : stimulus
    int         rand_items;
    int         phase_no;
    int         hot;
    int         nxt;
    int         n;
    int         idx;
    int         wd;
    bit         hold;
    logic       en;
    logic [7:0] act;
    rand_items = 0;
    phase_no = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(wae_pkg::CFG_ENABLE, 8'h00);
    write_reg(wae_pkg::CFG_ACTIVE, 8'h00);

    tx_idle_pct = 33;
    rx_idle_pct = 87;
    @(negedge clk);
    push_query(3, 9, 0, 1'b0);
    push_write(0, 3, 10, 30, 1'b0);
    push_write(1, 4, 5, 0, 1'b0);
    push_write(2, 6, 23, 59, 1'b0);
    push_write(3, 0, 0, 0, 1'b0);
    push_write(4, 7, 31, 63, 1'b0);
    push_write(127, 5, 12, 0, 1'b0);
    wait_idle();

    write_reg(wae_pkg::CFG_ENABLE, 8'h01);
    @(negedge clk);
    push_query(3, 9, 0, 1'b0);
    wait_idle();

    write_reg(wae_pkg::CFG_ACTIVE, 8'd5);
    @(negedge clk);
    push_query(3, 9, 0, 1'b0);
    push_query(3, 10, 30, 1'b0);
    push_query(6, 12, 0, 1'b0);
    push_query(6, 23, 59, 1'b0);
    push_query(7, 31, 63, 1'b0);
    push_query(7, 0, 0, 1'b0);
    push_query(5, 0, 0, 1'b0);
    push_query(0, 0, 0, 1'b0);
    push_query(2, 23, 59, 1'b0);
    push_query(1, 31, 63, 1'b0);
    wait_idle();

    write_reg(wae_pkg::CFG_ENABLE, 8'hfe);
    @(negedge clk);
    push_query(3, 9, 0, 1'b0);
    wait_idle();

    while (rand_items < 600) begin
      hot = $urandom_range(7);
      nxt = (hot == wae_pkg::LAST_WEEKDAY) ? 0 : hot + 1;
      en = ($urandom_range(9) != 0);
      case ($urandom_range(4))
        0: act = 8'd0;
        1: act = 8'(written_upto);
        2: begin
          if (written_upto == TABLE_DEPTH)
            act = $urandom_range(1) ? 8'd255 : 8'($urandom_range(129, 255));
          else
            act = 8'(written_upto);
        end
        default: act = 8'($urandom_range(1, written_upto));
      endcase
      write_reg(wae_pkg::CFG_ENABLE, {7'($urandom), en});
      write_reg(wae_pkg::CFG_ACTIVE, act);
      @(negedge clk);
      if (rand_items < 200) begin
        tx_idle_pct = 33;
        rx_idle_pct = 87;
      end else if (rand_items < 400) begin
        tx_idle_pct = 87;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      n = $urandom_range(20, 50);
      for (int k = 0; k < n; k++) begin
        hold = (k == 0 && phase_no % 4 == 1) || ($urandom_range(63) == 0);
        if ($urandom_range(99) < ((written_upto < TABLE_DEPTH) ? 50 : 20)) begin
          if (written_upto < TABLE_DEPTH && $urandom_range(4) != 0) idx = written_upto;
          else idx = $urandom_range(TABLE_DEPTH - 1);
          if ($urandom_range(99) < 85) begin
            wd = cold_weekday(hot, nxt);
          end else begin
            case ($urandom_range(2))
              0: wd = hot;
              1: wd = (nxt > 7) ? hot : nxt;
              default: wd = 7;
            endcase
          end
          push_write(idx, wd, rand_hour(), rand_minute(), hold);
        end else begin
          wd = ($urandom_range(99) < 80) ? hot : $urandom_range(7);
          push_query(wd, rand_hour(), rand_minute(), hold);
        end
        rand_items++;
      end
      wait_idle();
      phase_no++;
    end

    repeat (150) @(posedge clk);
    if (mismatches == 0 && alarm_q.size() == 0) begin
      $display("tb_weekly_alarm_entry_search OK");
    end else begin
      $display("tb_weekly_alarm_entry_search NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wae_pkg.sv
hdl/wae_table.sv
hdl/wae_match.sv
hdl/weekly_alarm_entry_search.sv
bench/tb_weekly_alarm_entry_search.sv
